[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition c in the same cycle, outside of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error(msg);

// A reset cycle is followed by condition c in the next cycle.
`define ASSERT_AFTER_RESET(label, clk, rst_n, c, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (c)) \
    else $error(msg);

`endif

[sv/isp_pkg.sv]
// ---------------------------------------------------------------------------
// isp_pkg
// Types, constants and tables of the infinite element shape index splitter.
// ---------------------------------------------------------------------------
package isp_pkg;

  // Default width of the combined shape index.
  localparam int ISP_INDEX_BITS = 12;

  // Widths of the derived interval bounds and of an outer interval offset.
  localparam int BOUND_W     = 12;
  localparam int OFF_W       = 10;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 14;
  localparam int NUM_LIMITS  = 7;

  // Element kinds.
  typedef enum logic [2:0] {
    ELEM_EDGE2   = 3'd0,
    ELEM_QUAD4   = 3'd1,
    ELEM_QUAD6   = 3'd2,
    ELEM_HEX8    = 3'd3,
    ELEM_HEX16   = 3'd4,
    ELEM_HEX18   = 3'd5,
    ELEM_PRISM6  = 3'd6,
    ELEM_PRISM12 = 3'd7
  } elem_type_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ELEMENT_TYPE = 3'd0,
    REG_RAD_ORDER    = 3'd1,
    REG_VERTEX_DOF   = 3'd2,
    REG_SIDE_DOF     = 3'd3,
    REG_FACE_DOF     = 3'd4,
    REG_INTERIOR_DOF = 3'd5
  } cfg_reg_t;

  // Base node counts per element kind.
  localparam logic [2:0] VERT_NODES [8] = '{3'd1, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3};
  localparam logic [2:0] SIDE_NODES [8] = '{3'd0, 3'd0, 3'd1, 3'd0, 3'd4, 3'd4, 3'd0, 3'd3};
  localparam logic [2:0] FACE_NODES [8] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0};

  // Reciprocals ceil(2^14 / r); exact quotients for any 10-bit dividend and r below 16.
  localparam logic [RECIP_W-1:0] RECIP [16] = '{
    15'd0,    15'd16384, 15'd8192, 15'd5462, 15'd4096, 15'd3277, 15'd2731, 15'd2341,
    15'd2048, 15'd1821,  15'd1639, 15'd1490, 15'd1366, 15'd1261, 15'd1171, 15'd1093
  };

  // Configuration register file.
  typedef struct packed {
    elem_type_t  element_type;
    logic [3:0]  rad_order;
    logic [3:0]  vertex_dof;
    logic [3:0]  side_dof;
    logic [3:0]  face_dof;
    logic [5:0]  interior_dof;
  } cfg_t;

  // Interval upper limits and base offsets of one item.
  typedef struct packed {
    logic [NUM_LIMITS-1:0][BOUND_W-1:0] lim;
    logic [BOUND_W-1:0]                 total;
    logic [7:0]                         add_side;
    logic [7:0]                         add_face;
    logic [7:0]                         add_int;
    logic [3:0]                         r;
  } bounds_t;

  // Located interval of one item.
  typedef struct packed {
    logic             err;
    logic             outer;
    logic [OFF_W-1:0] off;
    logic [7:0]       add;
    logic [3:0]       r;
  } loc_t;

  // Located item with its quotient.
  typedef struct packed {
    loc_t             loc;
    logic [OFF_W-1:0] quot;
  } div_t;

  // Result beat.
  typedef struct packed {
    logic [7:0] base_index;
    logic [3:0] radial_index;
    logic       out_of_range;
  } res_t;

endpackage

[sv/isp_bounds.sv]
// ---------------------------------------------------------------------------
// isp_bounds
// First stage: derives the interval limits from the configuration.
// ---------------------------------------------------------------------------
module isp_bounds #(
  parameter int INDEX_BITS = isp_pkg::ISP_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  isp_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INDEX_BITS-1:0] in_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_BITS-1:0] out_index,
  output isp_pkg::bounds_t      out_bounds
);
  import isp_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [INDEX_BITS-1:0] index_r;
  bounds_t               bounds_r, bounds_nxt;
  logic                  load;
  logic [BOUND_W-1:0]    p, bv, bs, bf, be, av, as_s, af, sum;

  // Stage handshake.
  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // Base dof counts, outer shell counts and cumulative limits.
  always_comb begin
    p    = BOUND_W'(cfg.rad_order) + BOUND_W'(1);
    bv   = BOUND_W'(VERT_NODES[cfg.element_type]) * BOUND_W'(cfg.vertex_dof);
    bs   = BOUND_W'(SIDE_NODES[cfg.element_type]) * BOUND_W'(cfg.side_dof);
    bf   = BOUND_W'(FACE_NODES[cfg.element_type]) * BOUND_W'(cfg.face_dof);
    be   = BOUND_W'(cfg.interior_dof);
    av   = bv * p;
    as_s = bs * p;
    af   = bf * p;
    sum  = bv + bs + bf + be;
    bounds_nxt.lim[0]   = bv;
    bounds_nxt.lim[1]   = av;
    bounds_nxt.lim[2]   = av + bs;
    bounds_nxt.lim[3]   = av + as_s;
    bounds_nxt.lim[4]   = av + as_s + bf;
    bounds_nxt.lim[5]   = av + as_s + af;
    bounds_nxt.lim[6]   = av + as_s + af + be;
    bounds_nxt.total    = (cfg.element_type == ELEM_EDGE2) ? p : sum * p;
    bounds_nxt.add_side = bv[7:0];
    bounds_nxt.add_face = bv[7:0] + bs[7:0];
    bounds_nxt.add_int  = bv[7:0] + bs[7:0] + bf[7:0];
    bounds_nxt.r        = cfg.rad_order;
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      index_r  <= in_index;
      bounds_r <= bounds_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_index  = index_r;
  assign out_bounds = bounds_r;

endmodule

[sv/isp_locate.sv]
// ---------------------------------------------------------------------------
// isp_locate
// Second stage: places the index in its interval and forms the offset.
// ---------------------------------------------------------------------------
module isp_locate #(
  parameter int INDEX_BITS = isp_pkg::ISP_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INDEX_BITS-1:0] in_index,
  input  isp_pkg::bounds_t      in_bounds,
  output logic                  out_valid,
  input  logic                  out_ready,
  output isp_pkg::loc_t         out_loc
);
  import isp_pkg::*;

  localparam int CW = (INDEX_BITS > BOUND_W) ? INDEX_BITS : BOUND_W;

  logic          valid_r, valid_nxt;
  loc_t          loc_r, loc_nxt;
  logic          load;
  logic [CW-1:0] idx, lo, diff;
  logic [2:0]    sel;
  logic [7:0]    add;

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // Interval search: first limit above the index, else the last interval.
  always_comb begin
    idx = CW'(in_index);
    sel = 3'd7;
    for (int k = NUM_LIMITS - 1; k >= 0; k--) begin
      if (idx < CW'(in_bounds.lim[k])) begin
        sel = 3'(k);
      end
    end
  end

  // Lower bound and base offset of the chosen interval.
  always_comb begin
    case (sel)
      3'd0: begin lo = '0;                        add = 8'd0;               end
      3'd1: begin lo = CW'(in_bounds.lim[0]);     add = 8'd0;               end
      3'd2: begin lo = CW'(in_bounds.lim[1]);     add = in_bounds.add_side; end
      3'd3: begin lo = CW'(in_bounds.lim[2]);     add = in_bounds.add_side; end
      3'd4: begin lo = CW'(in_bounds.lim[3]);     add = in_bounds.add_face; end
      3'd5: begin lo = CW'(in_bounds.lim[4]);     add = in_bounds.add_face; end
      3'd6: begin lo = CW'(in_bounds.lim[5]);     add = 8'd0;               end
      default: begin lo = CW'(in_bounds.lim[6]);  add = in_bounds.add_int;  end
    endcase
    diff          = idx - lo;
    loc_nxt.err   = !(idx < CW'(in_bounds.total));
    loc_nxt.outer = sel[0];
    loc_nxt.off   = diff[OFF_W-1:0];
    loc_nxt.add   = add;
    loc_nxt.r     = in_bounds.r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      loc_r <= loc_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_loc   = loc_r;

endmodule

[sv/isp_divide.sv]
// ---------------------------------------------------------------------------
// isp_divide
// Third and fourth stages: reciprocal division by the radial order and the
// result register.
// ---------------------------------------------------------------------------
module isp_divide (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  isp_pkg::loc_t  in_loc,
  output logic           out_valid,
  input  logic           out_ready,
  output isp_pkg::res_t  out_res
);
  import isp_pkg::*;
  `include "assert_macros.svh"

  logic                       s3_valid_r, s3_valid_nxt;
  div_t                       s3_r, s3_nxt;
  logic                       s4_valid_r, s4_valid_nxt;
  res_t                       res_r, res_nxt;
  logic                       s3_ready, s3_load, s4_load;
  logic [OFF_W+RECIP_W-1:0]   prod;
  logic [OFF_W+3:0]           qr;
  logic [OFF_W-1:0]           rem;

  // Handshake of both stages.
  assign s3_ready     = !s4_valid_r || out_ready;
  assign in_ready     = !s3_valid_r || s3_ready;
  assign s3_load      = in_valid && in_ready;
  assign s4_load      = s3_valid_r && s3_ready;
  assign s3_valid_nxt = in_ready ? in_valid : s3_valid_r;
  assign s4_valid_nxt = s3_ready ? s3_valid_r : s4_valid_r;

  // Quotient by multiplication with the reciprocal of the radial order.
  always_comb begin
    prod        = OFF_W'(in_loc.off) * RECIP[in_loc.r];
    s3_nxt.loc  = in_loc;
    s3_nxt.quot = prod[RECIP_SHIFT +: OFF_W];
  end

  // Remainder and the final result fields.
  always_comb begin
    qr  = (OFF_W + 4)'(s3_r.quot) * (OFF_W + 4)'(s3_r.loc.r);
    rem = s3_r.loc.off - qr[OFF_W-1:0];
    res_nxt.out_of_range = s3_r.loc.err;
    if (s3_r.loc.err) begin
      res_nxt.base_index   = 8'd0;
      res_nxt.radial_index = 4'd0;
    end else if (!s3_r.loc.outer) begin
      res_nxt.base_index   = s3_r.loc.off[7:0] + s3_r.loc.add;
      res_nxt.radial_index = 4'd0;
    end else if (s3_r.loc.r == 4'd0) begin
      res_nxt.base_index   = 8'd0;
      res_nxt.radial_index = 4'd0;
    end else begin
      res_nxt.base_index   = s3_r.quot[7:0] + s3_r.loc.add;
      res_nxt.radial_index = rem[3:0] + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s3_valid_nxt;
      s4_valid_r <= s4_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_r <= s3_nxt;
    end
    if (s4_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = s4_valid_r;
  assign out_res   = res_r;

  // The reciprocal quotient is exact: the remainder stays below the divisor.
  `ASSERT_IMPLIES(a_rem_below_divisor, clk, rst_n, s3_valid_r && s3_r.loc.outer && (s3_r.loc.r != 4'd0), rem < OFF_W'(s3_r.loc.r), "reciprocal quotient off by one")

endmodule

[sv/infinite_element_shape_index_split_unit.sv]
// ---------------------------------------------------------------------------
// infinite_element_shape_index_split_unit
// Splits a combined infinite element shape index into base and radial index.
// ---------------------------------------------------------------------------
// Usage:
// - Input beats on in_* carry one combined shape index each. Result beats on
//   out_* carry the base index and the radial index, with an out-of-range flag
//   in out_tuser; a flagged beat has both indexes zero.
// - The cfg_* channel writes the element type, radial order and dof counts,
//   one register per beat; cfg_ready is always high. Write only while no
//   beat is in flight.
// - Four register stages: limits, interval search, reciprocal multiply,
//   remainder and result. An accepted beat passes through them in that order
//   to out_tvalid; one beat is accepted per cycle while out_tready is high.
// - A stalled receiver fills the stages; in_tready falls once all four hold
//   a beat, and no beat is dropped or repeated.
// - Synchronous reset empties the stages and loads the register defaults:
//   edge2, radial order 1, one dof per vertex, all other counts zero.
// ---------------------------------------------------------------------------
module infinite_element_shape_index_split_unit #(
  parameter int INDEX_BITS = isp_pkg::ISP_INDEX_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input beat: tdata = shape_index, zero padded to whole bytes.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((INDEX_BITS+7)/8)*8-1:0]    in_tdata,
  // Result beat: tdata = base_index[7:0], radial_index[11:8], zeros above.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,
  // tuser = out_of_range.
  output logic [0:0]                         out_tuser,
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [2:0]                         cfg_index,
  input  logic [5:0]                         cfg_data
);
  import isp_pkg::*;
  `include "assert_macros.svh"

  cfg_t                  cfg_r, cfg_nxt;
  logic                  s1_valid, s1_ready, s2_valid, s2_ready;
  logic [INDEX_BITS-1:0] s1_index;
  bounds_t               s1_bounds;
  loc_t                  s2_loc;
  res_t                  res;

  // Configuration register file.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ELEMENT_TYPE: cfg_nxt.element_type = elem_type_t'(cfg_data[2:0]);
        REG_RAD_ORDER:    cfg_nxt.rad_order    = cfg_data[3:0];
        REG_VERTEX_DOF:   cfg_nxt.vertex_dof   = cfg_data[3:0];
        REG_SIDE_DOF:     cfg_nxt.side_dof     = cfg_data[3:0];
        REG_FACE_DOF:     cfg_nxt.face_dof     = cfg_data[3:0];
        REG_INTERIOR_DOF: cfg_nxt.interior_dof = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.element_type <= ELEM_EDGE2;
      cfg_r.rad_order    <= 4'd1;
      cfg_r.vertex_dof   <= 4'd1;
      cfg_r.side_dof     <= 4'd0;
      cfg_r.face_dof     <= 4'd0;
      cfg_r.interior_dof <= 6'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Pipeline stages.
  isp_bounds #(.INDEX_BITS(INDEX_BITS)) u_bounds (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_index   (in_tdata[INDEX_BITS-1:0]),
    .out_valid  (s1_valid),
    .out_ready  (s1_ready),
    .out_index  (s1_index),
    .out_bounds (s1_bounds)
  );

  isp_locate #(.INDEX_BITS(INDEX_BITS)) u_locate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_index  (s1_index),
    .in_bounds (s1_bounds),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_loc   (s2_loc)
  );

  isp_divide u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_loc    (s2_loc),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Result beat packing.
  assign out_tdata = {4'd0, res.radial_index, res.base_index};
  assign out_tuser = res.out_of_range;

  // Reset empties every stage.
  `ASSERT_AFTER_RESET(a_reset_empty, clk, rst_n, !out_tvalid, "result valid right after reset")
  // With the result stage empty, the pipeline always has room.
  `ASSERT_IMPLIES(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready, "input stalled with empty output")
  // A flagged beat carries zero indexes.
  `ASSERT_IMPLIES(a_err_zero_fields, clk, rst_n, out_tvalid && out_tuser[0], out_tdata[11:0] == 12'd0, "out-of-range beat with nonzero indexes")

endmodule
